// ----- rtl/bcf_pkg.sv -----
// ----------------------------------------------------------------------------
// bcf_pkg
// Shared types, constants and weight table for the Bezier flattener.
// ----------------------------------------------------------------------------
package bcf_pkg;

    localparam int COORD_W = 32;
    localparam int W_W     = 10;
    localparam int PROD_W  = COORD_W + W_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int SHIFT   = 9;
    localparam int STEP_W  = 3;
    localparam int ADDR_W  = 3;

    localparam logic [STEP_W-1:0] STEP_ANCHOR = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_LAST   = STEP_W'(7);
    localparam logic [SUM_W-1:0]  ROUND_HALF  = SUM_W'(256);
    localparam logic              REG_OPEN_PATH = 1'b0;

    // Row 0 copies the start anchor exactly; rows 1..7 are t = s/8.
    localparam logic [W_W-1:0] BERN [8][4] = '{
        '{W_W'(512), W_W'(0),   W_W'(0),   W_W'(0)},
        '{W_W'(343), W_W'(147), W_W'(21),  W_W'(1)},
        '{W_W'(216), W_W'(216), W_W'(72),  W_W'(8)},
        '{W_W'(125), W_W'(225), W_W'(135), W_W'(27)},
        '{W_W'(64),  W_W'(192), W_W'(192), W_W'(64)},
        '{W_W'(27),  W_W'(135), W_W'(225), W_W'(125)},
        '{W_W'(8),   W_W'(72),  W_W'(216), W_W'(216)},
        '{W_W'(1),   W_W'(21),  W_W'(147), W_W'(343)}
    };

    typedef logic [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t ax;
        coord_t ay;
        coord_t aox;
        coord_t aoy;
        coord_t bix;
        coord_t biy;
        coord_t bx;
        coord_t by;
    } seg_t;

    typedef struct packed {
        coord_t anchor_x;
        coord_t anchor_y;
        coord_t handle_in_x;
        coord_t handle_in_y;
        coord_t handle_out_x;
        coord_t handle_out_y;
        logic   last_point;
    } item_t;

    typedef struct packed {
        seg_t              seg;
        logic [STEP_W-1:0] widx;
        logic              is_sample;
        logic              last;
    } desc_t;

    function automatic logic seg_curved(input seg_t s);
        seg_curved = (s.aox != s.ax) || (s.aoy != s.ay) ||
                     (s.bix != s.bx) || (s.biy != s.by);
    endfunction

endpackage

// ----- rtl/bcf_seq.sv -----
// ----------------------------------------------------------------------------
// bcf_seq
// Path state and result sequencer: turns each anchor into up to two segment
// jobs and issues one point descriptor per cycle while adv is high.
// ----------------------------------------------------------------------------
module bcf_seq (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  bcf_pkg::item_t  in_item,
    input  logic            open_path,
    input  logic            adv,
    output logic            desc_valid,
    output bcf_pkg::desc_t  desc
);

    logic                       have_first_reg, have_first_next;
    logic                       job_valid_reg, job_valid_next;
    logic                       slot_reg, slot_next;
    logic                       slot1_valid_reg, slot1_valid_next;
    logic [bcf_pkg::STEP_W-1:0] step_reg, step_next;
    logic                       curved0_reg, curved0_next;
    logic                       curved1_reg, curved1_next;
    bcf_pkg::seg_t              seg0_reg, seg0_next;
    bcf_pkg::seg_t              seg1_reg, seg1_next;
    bcf_pkg::coord_t            first_x_reg, first_y_reg, first_in_x_reg, first_in_y_reg;
    bcf_pkg::coord_t            prev_x_reg, prev_y_reg, prev_out_x_reg, prev_out_y_reg;
    logic                       d_valid_reg, d_valid_next;
    bcf_pkg::desc_t             d_reg, d_next;

    bcf_pkg::seg_t cur_seg;
    bcf_pkg::seg_t new_seg0;
    bcf_pkg::seg_t new_seg1;
    logic          cur_curved;
    logic          step_last;
    logic          job_last;
    logic          emit;
    logic          accept;
    logic          load_job;

    always_comb begin
        cur_seg    = slot_reg ? seg1_reg : seg0_reg;
        cur_curved = slot_reg ? curved1_reg : curved0_reg;
        step_last  = !cur_curved || (step_reg == bcf_pkg::STEP_LAST);
        job_last   = step_last && (slot_reg || !slot1_valid_reg);
        emit       = job_valid_reg && adv;
        in_ready   = !job_valid_reg || (emit && job_last);
        accept     = in_valid && in_ready;
        load_job   = accept && (have_first_reg || in_item.last_point);

        if (have_first_reg) begin
            new_seg0 = '{prev_x_reg, prev_y_reg, prev_out_x_reg, prev_out_y_reg,
                         in_item.handle_in_x, in_item.handle_in_y,
                         in_item.anchor_x, in_item.anchor_y};
        end else begin
            // single point path: flat segment that copies the anchor
            new_seg0 = '{in_item.anchor_x, in_item.anchor_y,
                         in_item.anchor_x, in_item.anchor_y,
                         in_item.anchor_x, in_item.anchor_y,
                         in_item.anchor_x, in_item.anchor_y};
        end
        new_seg1 = '{in_item.anchor_x, in_item.anchor_y,
                     in_item.handle_out_x, in_item.handle_out_y,
                     first_in_x_reg, first_in_y_reg, first_x_reg, first_y_reg};
    end

    always_comb begin
        have_first_next  = have_first_reg;
        job_valid_next   = job_valid_reg;
        slot_next        = slot_reg;
        slot1_valid_next = slot1_valid_reg;
        step_next        = step_reg;
        curved0_next     = curved0_reg;
        curved1_next     = curved1_reg;
        seg0_next        = seg0_reg;
        seg1_next        = seg1_reg;
        d_valid_next     = d_valid_reg;
        d_next           = d_reg;

        if (adv) begin
            d_valid_next = emit;
        end
        if (emit) begin
            d_next.seg       = cur_seg;
            d_next.widx      = step_reg;
            d_next.is_sample = (step_reg != bcf_pkg::STEP_ANCHOR);
            d_next.last      = job_last;
            if (job_last) begin
                job_valid_next = 1'b0;
            end else if (step_last) begin
                slot_next = 1'b1;
                step_next = bcf_pkg::STEP_ANCHOR;
            end else begin
                step_next = step_reg + 1'b1;
            end
        end

        if (accept) begin
            have_first_next = !in_item.last_point;
        end
        if (load_job) begin
            job_valid_next   = 1'b1;
            slot_next        = 1'b0;
            step_next        = bcf_pkg::STEP_ANCHOR;
            seg0_next        = new_seg0;
            curved0_next     = have_first_reg && bcf_pkg::seg_curved(new_seg0);
            seg1_next        = new_seg1;
            slot1_valid_next = have_first_reg && in_item.last_point;
            // open path: wrap slot degenerates to a copy of the final anchor
            curved1_next     = !open_path && bcf_pkg::seg_curved(new_seg1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_first_reg  <= 1'b0;
            job_valid_reg   <= 1'b0;
            slot_reg        <= 1'b0;
            slot1_valid_reg <= 1'b0;
            step_reg        <= bcf_pkg::STEP_ANCHOR;
            d_valid_reg     <= 1'b0;
        end else begin
            have_first_reg  <= have_first_next;
            job_valid_reg   <= job_valid_next;
            slot_reg        <= slot_next;
            slot1_valid_reg <= slot1_valid_next;
            step_reg        <= step_next;
            d_valid_reg     <= d_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        curved0_reg <= curved0_next;
        curved1_reg <= curved1_next;
        seg0_reg    <= seg0_next;
        seg1_reg    <= seg1_next;
        d_reg       <= d_next;
        if (accept && !have_first_reg && !in_item.last_point) begin
            first_x_reg    <= in_item.anchor_x;
            first_y_reg    <= in_item.anchor_y;
            first_in_x_reg <= in_item.handle_in_x;
            first_in_y_reg <= in_item.handle_in_y;
        end
        if (accept && !in_item.last_point) begin
            prev_x_reg     <= in_item.anchor_x;
            prev_y_reg     <= in_item.anchor_y;
            prev_out_x_reg <= in_item.handle_out_x;
            prev_out_y_reg <= in_item.handle_out_y;
        end
    end

    assign desc_valid = d_valid_reg;
    assign desc       = d_reg;

endmodule

// ----- rtl/bcf_blend.sv -----
// ----------------------------------------------------------------------------
// bcf_blend
// Two-stage Bernstein blend: weighted products, then rounded sum into the
// result register.
// ----------------------------------------------------------------------------
module bcf_blend (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            adv,
    input  logic            desc_valid,
    input  bcf_pkg::desc_t  desc,
    output logic            out_valid,
    output bcf_pkg::coord_t out_x,
    output bcf_pkg::coord_t out_y,
    output logic            out_sample,
    output logic            out_last
);

    logic signed [bcf_pkg::PROD_W-1:0] px_reg [4];
    logic signed [bcf_pkg::PROD_W-1:0] py_reg [4];
    logic signed [bcf_pkg::PROD_W-1:0] px_next [4];
    logic signed [bcf_pkg::PROD_W-1:0] py_next [4];
    logic                              p_valid_reg;
    logic                              p_sample_reg;
    logic                              p_last_reg;

    logic                              o_valid_reg;
    bcf_pkg::coord_t                   ox_reg, oy_reg, ox_next, oy_next;
    logic                              o_sample_reg;
    logic                              o_last_reg;

    bcf_pkg::coord_t                   cx [4];
    bcf_pkg::coord_t                   cy [4];
    logic signed [bcf_pkg::PROD_W-1:0] ex, ey, ew;
    logic signed [bcf_pkg::SUM_W-1:0]  sum_x, sum_y;

    always_comb begin
        cx[0] = desc.seg.ax;  cy[0] = desc.seg.ay;
        cx[1] = desc.seg.aox; cy[1] = desc.seg.aoy;
        cx[2] = desc.seg.bix; cy[2] = desc.seg.biy;
        cx[3] = desc.seg.bx;  cy[3] = desc.seg.by;
        ex = '0;
        ey = '0;
        ew = '0;
        for (int j = 0; j < 4; j++) begin
            ex = bcf_pkg::PROD_W'($signed(cx[j]));
            ey = bcf_pkg::PROD_W'($signed(cy[j]));
            ew = $signed(bcf_pkg::PROD_W'(bcf_pkg::BERN[desc.widx][j]));
            px_next[j] = ex * ew;
            py_next[j] = ey * ew;
        end
    end

    always_comb begin
        sum_x = $signed(bcf_pkg::ROUND_HALF);
        sum_y = $signed(bcf_pkg::ROUND_HALF);
        for (int j = 0; j < 4; j++) begin
            sum_x = sum_x + bcf_pkg::SUM_W'(px_reg[j]);
            sum_y = sum_y + bcf_pkg::SUM_W'(py_reg[j]);
        end
        // floor of sum / 512
        ox_next = sum_x[bcf_pkg::COORD_W+bcf_pkg::SHIFT-1:bcf_pkg::SHIFT];
        oy_next = sum_y[bcf_pkg::COORD_W+bcf_pkg::SHIFT-1:bcf_pkg::SHIFT];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else if (adv) begin
            p_valid_reg <= desc_valid;
            o_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j < 4; j++) begin
                px_reg[j] <= px_next[j];
                py_reg[j] <= py_next[j];
            end
            p_sample_reg <= desc.is_sample;
            p_last_reg   <= desc.last;
            ox_reg       <= ox_next;
            oy_reg       <= oy_next;
            o_sample_reg <= p_sample_reg;
            o_last_reg   <= p_last_reg;
        end
    end

    assign out_valid  = o_valid_reg;
    assign out_x      = ox_reg;
    assign out_y      = oy_reg;
    assign out_sample = o_sample_reg;
    assign out_last   = o_last_reg;

endmodule

// ----- rtl/cubic_bezier_flattener.sv -----
// ----------------------------------------------------------------------------
// cubic_bezier_flattener
// Streams path anchors in, streams flattened outline points out.
// ----------------------------------------------------------------------------
// Each anchor transfer yields 0, 1, 2, 8, 9 or 16 result transfers: an anchor
// copy per segment plus seven samples when the segment is curved, and the wrap
// segment or the final anchor at the end of the path. Results leave at one
// per cycle while m_tready does not stall them. The sequencer issuing those
// points sets the rate: the next anchor is taken in the cycle the previous
// anchor's last point is issued, or at once when nothing is pending. Each
// point passes the sequencer's descriptor register and the blend's product
// and result registers. open_path is sampled when the final anchor is taken.
// ----------------------------------------------------------------------------
module cubic_bezier_flattener (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_tvalid,
    output logic                           s_tready,
    // anchor_x, anchor_y, handle_in_x, handle_in_y, handle_out_x, handle_out_y
    input  logic [6*bcf_pkg::COORD_W-1:0]  s_tdata,
    input  logic                           s_tlast,

    output logic                           m_tvalid,
    input  logic                           m_tready,
    // point_x, point_y
    output logic [2*bcf_pkg::COORD_W-1:0]  m_tdata,
    // is_sample
    output logic                           m_tuser,
    output logic                           m_tlast,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bcf_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    logic            open_path_reg;
    logic            adv;
    logic            desc_valid;
    bcf_pkg::desc_t  desc;
    bcf_pkg::item_t  item;
    bcf_pkg::coord_t out_x, out_y;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_path_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == bcf_pkg::REG_OPEN_PATH) begin
            open_path_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == bcf_pkg::REG_OPEN_PATH) ? {31'd0, open_path_reg} : 32'd0;

    assign item = '{s_tdata[0*bcf_pkg::COORD_W +: bcf_pkg::COORD_W],
                    s_tdata[1*bcf_pkg::COORD_W +: bcf_pkg::COORD_W],
                    s_tdata[2*bcf_pkg::COORD_W +: bcf_pkg::COORD_W],
                    s_tdata[3*bcf_pkg::COORD_W +: bcf_pkg::COORD_W],
                    s_tdata[4*bcf_pkg::COORD_W +: bcf_pkg::COORD_W],
                    s_tdata[5*bcf_pkg::COORD_W +: bcf_pkg::COORD_W],
                    s_tlast};

    assign adv = !m_tvalid || m_tready;

    bcf_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (item),
        .open_path  (open_path_reg),
        .adv        (adv),
        .desc_valid (desc_valid),
        .desc       (desc)
    );

    bcf_blend u_blend (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .desc_valid (desc_valid),
        .desc       (desc),
        .out_valid  (m_tvalid),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_sample (m_tuser),
        .out_last   (m_tlast)
    );

    assign m_tdata = {out_y, out_x};

endmodule

// ----- test/tb_cubic_bezier_flattener.sv -----
// ----------------------------------------------------------------------------
// tb_cubic_bezier_flattener
// Streams Bezier path anchors into the flattener, predicts every outline point
// (anchor copies and the seven Bernstein samples of curved segments, wrap or
// end point per path mode) and checks each result transfer in order. Runs a
// directed set, then random paths under several handshake idling mixes.
// ----------------------------------------------------------------------------
module tb_cubic_bezier_flattener;

    typedef bcf_pkg::coord_t coord_t;

    localparam int          LIMIT    = 400_000;
    localparam int          SETTLE   = 16;
    localparam int          HOLD_LEN = 400;
    localparam int          N_REGS   = 1;
    localparam int          REG_OPEN = 0;
    localparam coord_t      MINC     = 32'h8000_0000;
    localparam coord_t      MAXC     = 32'h7FFF_FFFF;

    typedef struct {
        coord_t ax, ay, inx, iny, outx, outy;
        bit     path_end;
    } anchor_t;

    typedef struct {
        coord_t x, y;
        bit     smp;
        bit     last_pt;
    } outline_pt_t;

    class flatten_scoreboard;
        bit          open_path;
        bit          have_first;
        coord_t      first_x, first_y, first_in_x, first_in_y;
        coord_t      prev_x, prev_y, prev_out_x, prev_out_y;
        outline_pt_t expected_pts[$];
        int          errors;

        function coord_t bern_mix(int s, coord_t p0, coord_t p1, coord_t p2, coord_t p3);
            longint t, u, acc;
            t = s;
            u = 8 - s;
            acc = u * u * u * $signed(p0) + 3 * u * u * t * $signed(p1)
                + 3 * u * t * t * $signed(p2) + t * t * t * $signed(p3) + 256;
            return coord_t'(acc >>> 9);
        endfunction

        function void push_point(coord_t x, coord_t y, bit smp);
            outline_pt_t p;
            p.x = x;
            p.y = y;
            p.smp = smp;
            p.last_pt = 1'b0;
            expected_pts.insert(expected_pts.size(), p);
        endfunction

        function void push_segment(coord_t ax, coord_t ay, coord_t aox, coord_t aoy,
                                   coord_t bix, coord_t biy, coord_t bx, coord_t by);
            push_point(ax, ay, 1'b0);
            if (aox != ax || aoy != ay || bix != bx || biy != by)
                for (int s = 1; s < 8; s++)
                    push_point(bern_mix(s, ax, aox, bix, bx), bern_mix(s, ay, aoy, biy, by),
                               1'b1);
        endfunction

        function void note_anchor(anchor_t a);
            int n0;
            n0 = expected_pts.size();
            if (!have_first) begin
                if (a.path_end) begin
                    push_point(a.ax, a.ay, 1'b0);
                end else begin
                    first_x = a.ax;
                    first_y = a.ay;
                    first_in_x = a.inx;
                    first_in_y = a.iny;
                    prev_x = a.ax;
                    prev_y = a.ay;
                    prev_out_x = a.outx;
                    prev_out_y = a.outy;
                    have_first = 1'b1;
                end
            end else begin
                push_segment(prev_x, prev_y, prev_out_x, prev_out_y, a.inx, a.iny, a.ax, a.ay);
                if (a.path_end) begin
                    if (open_path)
                        push_point(a.ax, a.ay, 1'b0);
                    else
                        push_segment(a.ax, a.ay, a.outx, a.outy,
                                     first_in_x, first_in_y, first_x, first_y);
                    have_first = 1'b0;
                end else begin
                    prev_x = a.ax;
                    prev_y = a.ay;
                    prev_out_x = a.outx;
                    prev_out_y = a.outy;
                end
            end
            if (expected_pts.size() > n0)
                expected_pts[expected_pts.size() - 1].last_pt = 1'b1;
        endfunction

        function void check_point(coord_t x, coord_t y, bit smp, bit last_pt);
            outline_pt_t e;
            if (expected_pts.size() == 0) begin
                $error("unexpected point transfer: x=%h y=%h is_sample=%0d last=%0d",
                       x, y, smp, last_pt);
                errors++;
                return;
            end
            e = expected_pts.pop_front();
            if (x !== e.x) begin
                $error("point_x: expected %h, got %h", e.x, x);
                errors++;
            end
            if (y !== e.y) begin
                $error("point_y: expected %h, got %h", e.y, y);
                errors++;
            end
            if (smp !== e.smp) begin
                $error("is_sample: expected %0d, got %0d", e.smp, smp);
                errors++;
            end
            if (last_pt !== e.last_pt) begin
                $error("last_result: expected %0d, got %0d", e.last_pt, last_pt);
                errors++;
            end
        endfunction
    endclass

    logic                        aclk     = 1'b0;
    logic                        aresetn  = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [191:0]                s_tdata  = '0;
    logic                        s_tlast  = 1'b0;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [63:0]                 m_tdata;
    logic                        m_tuser;
    logic                        m_tlast;
    logic                        psel     = 1'b0;
    logic                        penable  = 1'b0;
    logic                        pwrite   = 1'b0;
    logic [bcf_pkg::ADDR_W-1:0]  paddr    = '0;
    logic [31:0]                 pwdata   = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    flatten_scoreboard   sb = new();
    int                  send_idle_pct  = 0;
    int                  recv_stall_pct = 0;
    int                  hold_req  = 0;
    int                  hold_done = 0;
    int                  hold_left = 0;
    int unsigned         cycle_count = 0;

    cubic_bezier_flattener dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("tb_cubic_bezier_flattener NOT OK");
            $finish;
        end
    end

    // result side: check transfers, random stalls, long hold-off on request
    always @(posedge aclk) begin
        if (m_tvalid && m_tready)
            sb.check_point(m_tdata[31:0], m_tdata[63:32], m_tuser, m_tlast);
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (hold_req != hold_done) begin
            hold_done <= hold_req;
            hold_left <= HOLD_LEN;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic anchor_t mk(coord_t ax, coord_t ay, coord_t inx, coord_t iny,
                                   coord_t outx, coord_t outy, bit path_end);
        anchor_t a;
        a.ax = ax;
        a.ay = ay;
        a.inx = inx;
        a.iny = iny;
        a.outx = outx;
        a.outy = outy;
        a.path_end = path_end;
        return a;
    endfunction

    function automatic coord_t rand_coord(int style);
        case (style)
            1: return coord_t'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
            2: case ($urandom_range(3))
                   0: return MINC;
                   1: return MAXC;
                   2: return '0;
                   default: return '1;
               endcase
            default: return $urandom();
        endcase
    endfunction

    function automatic coord_t rand_handle(coord_t a);
        case ($urandom_range(9))
            0, 1, 2: return a;
            3:       return a ^ (32'd1 << $urandom_range(31));
            4, 5, 6: return a + coord_t'($urandom_range(0, 4096)) - 32'd2048;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_anchor(input anchor_t a);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata <= {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {a.outy, a.outx, a.iny, a.inx, a.ay, a.ax};
        s_tlast <= a.path_end;
        do @(posedge aclk); while (!s_tready);
        sb.note_anchor(a);
    endtask

    task automatic flush_points();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.expected_pts.size() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic apb_write(input int index, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= bcf_pkg::ADDR_W'(4 * index);
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (index == REG_OPEN)
            sb.open_path = data[0];
    endtask

    task automatic set_path_mode(input bit open);
        flush_points();
        apb_write(REG_OPEN, ($urandom() & ~32'd1) | 32'(open));
    endtask

    task automatic send_random_path(inout int sent);
        int len;
        int style;
        anchor_t a;
        len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 6);
        style = $urandom_range(3);
        for (int i = 0; i < len; i++) begin
            a.ax = rand_coord(style);
            a.ay = rand_coord(style);
            if ($urandom_range(9) < 4) begin
                a.inx = a.ax;
                a.iny = a.ay;
                a.outx = a.ax;
                a.outy = a.ay;
            end else begin
                a.inx = rand_handle(a.ax);
                a.iny = rand_handle(a.ay);
                a.outx = rand_handle(a.ax);
                a.outy = rand_handle(a.ay);
            end
            a.path_end = (i == len - 1);
            send_anchor(a);
            sent++;
        end
    endtask

    task automatic run_random(input int n_items, input int s_pct, input int r_pct,
                              input bit open, input bit with_hold);
        int sent;
        sent = 0;
        set_path_mode(open);
        send_idle_pct = s_pct;
        recv_stall_pct = r_pct;
        if (with_hold)
            hold_req++;
        while (sent < n_items)
            send_random_path(sent);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // closed paths (reset mode)
        send_anchor(mk(MINC, MAXC, MINC, MAXC, MINC, MAXC, 1'b1));
        send_anchor(mk(0, 0, 0, 0, 0, 0, 1'b0));
        send_anchor(mk(32'h10000, 0, 32'h10000, 0, 32'h10000, 0, 1'b0));
        send_anchor(mk(0, 32'h10000, 0, 32'h10000, 0, 32'h10000, 1'b1));
        send_anchor(mk(MINC, MINC, MAXC, MAXC, MAXC, MAXC, 1'b0));
        send_anchor(mk(MAXC, MAXC, MINC, MINC, MINC, MINC, 1'b1));
        send_anchor(mk(100, 200, 100, 200, 101, 200, 1'b0));
        send_anchor(mk(-5, 7, -5, 7, -5, 7, 1'b0));
        send_anchor(mk(300, -300, 300, -299, 300, -300, 1'b0));
        send_anchor(mk(-1, -1, -1, -1, -1, -1, 1'b1));

        // open paths, then a write to a nonexistent register
        set_path_mode(1'b1);
        send_anchor(mk(1000, 1000, 1000, 1000, 5000, -3000, 1'b0));
        send_anchor(mk(-2000, 4000, 0, 0, -2000, 4000, 1'b0));
        send_anchor(mk(MAXC, MINC, MAXC, MINC, MAXC, MINC, 1'b1));
        flush_points();
        apb_write(N_REGS, 32'd0);
        send_anchor(mk(7, -7, 9, -9, 11, -11, 1'b1));
        send_anchor(mk(MAXC, MAXC, MINC, MINC, MINC, MAXC, 1'b0));
        send_anchor(mk(MINC, MINC, MAXC, MAXC, MAXC, MINC, 1'b1));

        run_random(116, 0, 0, 1'b0, 1'b1);
        run_random(116, 77, 0, 1'b1, 1'b0);
        run_random(116, 0, 77, 1'b0, 1'b0);
        run_random(116, 35, 35, 1'b1, 1'b0);

        flush_points();
        if (sb.errors == 0)
            $display("tb_cubic_bezier_flattener OK");
        else
            $display("tb_cubic_bezier_flattener NOT OK");
        $finish;
    end

endmodule
